// ----- rtl/core/sfd_pkg.sv -----
package sfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;

  localparam logic [ByteW-1:0]  SyncByte   = 8'hAA;
  localparam logic [ByteW-1:0]  EscByte    = 8'hFF;
  localparam logic [ByteW-1:0]  BcastLimit = 8'h10;
  localparam logic [CountW-1:0] HeaderLen  = 9'd5;
  localparam logic [CountW-1:0] LenBase    = 9'd3;
  localparam logic [CountW-1:0] ExtBase    = 9'd6;
  localparam logic [CountW-1:0] MaxCount   = 9'd260;

  localparam logic ActByte    = 1'b0;
  localparam logic ActTimeout = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] byte_count;
    logic [CountW-1:0] frame_total;
    logic [ByteW-1:0]  first_header_byte;
  } frame_state_t;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  data_byte;
    logic [CountW-1:0] position;
    logic              last;
    logic              aborted;
  } frame_result_t;

endpackage

// ----- rtl/core/sfd_step.sv -----
module sfd_step (
  input  sfd_pkg::frame_state_t  state_i,
  input  logic                   action_i,
  input  logic [7:0]             rx_byte_i,
  output sfd_pkg::frame_state_t  state_o,
  output sfd_pkg::frame_result_t result_o
);
  import sfd_pkg::*;

  logic              is_special;
  logic              in_esc;
  logic              do_emit;
  logic [ByteW-1:0]  emit_val;
  logic [CountW-1:0] next_pos;
  logic [ByteW-1:0]  fhb_new;
  logic [CountW-1:0] total_new;
  logic              emit_last;

  assign is_special = (rx_byte_i == EscByte) || (rx_byte_i == SyncByte);
  assign in_esc     = (state_i.phase == PH_ESC);
  assign emit_val   = in_esc ? ~rx_byte_i : rx_byte_i;
  assign do_emit    = (action_i == ActByte) && (state_i.phase != PH_HUNT)
                      && (in_esc || !is_special);
  assign next_pos   = state_i.byte_count + 9'd1;
  assign fhb_new    = (state_i.byte_count == '0) ? emit_val : state_i.first_header_byte;

  always_comb begin
    total_new = state_i.frame_total;
    if (next_pos == HeaderLen) begin
      if (fhb_new >= BcastLimit) begin
        total_new = {4'd0, fhb_new[7:4], 1'b0} + LenBase;
      end else begin
        total_new = ExtBase + {1'b0, emit_val};
      end
    end
  end

  assign emit_last = (next_pos >= HeaderLen) && (next_pos >= total_new);

  // next state
  always_comb begin
    state_o = state_i;
    if (action_i == ActTimeout) begin
      if (state_i.phase != PH_HUNT) begin
        state_o.phase             = PH_HUNT;
        state_o.byte_count        = '0;
        state_o.frame_total       = HeaderLen;
        state_o.first_header_byte = '0;
      end
    end else begin
      unique case (state_i.phase)
        PH_HUNT: begin
          if (rx_byte_i == SyncByte) begin
            state_o.phase       = PH_FRAME;
            state_o.byte_count  = '0;
            state_o.frame_total = HeaderLen;
          end
        end
        default: begin
          if (!in_esc && is_special) begin
            state_o.phase = PH_ESC;
          end else if (emit_last) begin
            state_o.phase             = PH_HUNT;
            state_o.byte_count        = '0;
            state_o.frame_total       = HeaderLen;
            state_o.first_header_byte = '0;
          end else begin
            state_o.phase             = PH_FRAME;
            state_o.byte_count        = next_pos;
            state_o.frame_total       = total_new;
            state_o.first_header_byte = fhb_new;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    result_o           = '0;
    result_o.position  = state_i.byte_count;
    if (action_i == ActTimeout) begin
      result_o.valid   = (state_i.phase != PH_HUNT);
      result_o.aborted = 1'b1;
    end else if (do_emit) begin
      result_o.valid     = 1'b1;
      result_o.data_byte = emit_val;
      result_o.last      = emit_last;
    end
  end

endmodule

// ----- rtl/core/serial_frame_deframer_core.sv -----
// Byte-stuffing deframer: hunts for the sync byte 0xAA, then unescapes frame
// bytes (0xFF or 0xAA escapes the next byte, which is sent inverted) and tags
// each with its position; the frame length comes from the header once five
// bytes are out, and the closing byte carries last. A timeout inside a frame
// yields one item with aborted set. One item is taken every clock cycle while
// the result register is free or being read; an item is held in the input
// register and its result, if any, is then held in the result register. The
// rate is set by the update loop of the frame state.
module serial_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [8:0] position_o,
  output logic       last_o,
  output logic       aborted_o
);
  import sfd_pkg::*;

  logic             in_valid_q;
  logic             action_q;
  logic [ByteW-1:0] rx_byte_q;
  frame_state_t     st_q, st_d;
  frame_result_t    res_d, res_q;
  logic             out_free;
  logic             advance;

  assign out_free   = !res_q.valid || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  sfd_step u_step (
    .state_i   (st_q),
    .action_i  (action_q),
    .rx_byte_i (rx_byte_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q  <= action_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase             <= PH_HUNT;
      st_q.byte_count        <= '0;
      st_q.frame_total       <= HeaderLen;
      st_q.first_header_byte <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      if (advance) begin
        res_q.valid <= res_d.valid;
      end else if (out_ready_i) begin
        res_q.valid <= 1'b0;
      end
      if (advance && res_d.valid) begin
        res_q.data_byte <= res_d.data_byte;
        res_q.position  <= res_d.position;
        res_q.last      <= res_d.last;
        res_q.aborted   <= res_d.aborted;
      end
    end
  end

  assign out_valid_o = res_q.valid;
  assign data_byte_o = res_q.data_byte;
  assign position_o  = res_q.position;
  assign last_o      = res_q.last;
  assign aborted_o   = res_q.aborted;

  a_abort_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aborted_o |-> !last_o && (data_byte_o == '0))
    else $error("aborted item carries data or last");

  a_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.valid && (res_d.last || res_d.aborted) |=> st_q.phase == PH_HUNT)
    else $error("frame end did not return to hunting");

  a_hunt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_HUNT |-> st_q.byte_count == '0)
    else $error("byte count not cleared while hunting");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> position_o >= (HeaderLen - 9'd1))
    else $error("last flagged inside header");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.byte_count <= MaxCount)
    else $error("byte count out of range");

endmodule
